[rtl/tgi_pkg.sv]
// Shared types, constants and helper functions for the turtle graphics interpreter.
// Depends on nothing; every other rtl file but tgi_ram refers to it by scoped names.
`default_nettype none

package tgi_pkg;

    // Field widths
    localparam int SYM_W     = 8;
    localparam int COORD_W   = 24;
    localparam int HEAD_W    = 9;
    localparam int STEP_W    = 16;
    localparam int KIND_W    = 2;
    localparam int TRIG_W    = 15;
    localparam int TRIG_SHIFT = 14;
    localparam int PROD_W    = STEP_W + TRIG_W;
    localparam int DELTA_W   = PROD_W - TRIG_SHIFT;
    localparam int TRIG_IDX_W = 7;

    // Configuration port
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;
    localparam int REG_IDX_LSB = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Angle constants, one bit wider than a heading
    localparam logic [HEAD_W:0] DEG_90  = 10'd90;
    localparam logic [HEAD_W:0] DEG_180 = 10'd180;
    localparam logic [HEAD_W:0] DEG_270 = 10'd270;
    localparam logic [HEAD_W:0] DEG_360 = 10'd360;

    // Rounding constant for the Q1.14 scale
    localparam logic [PROD_W-1:0] TRIG_ROUND = PROD_W'(1) << (TRIG_SHIFT - 1);

    // Register reset values
    localparam logic [STEP_W-1:0]  STEP_LENGTH_RST   = 16'd128;
    localparam logic [HEAD_W-1:0]  TURN_ANGLE_RST    = 9'd25;
    localparam logic [HEAD_W-1:0]  START_HEADING_RST = 9'd80;
    localparam logic [COORD_W-1:0] START_X_RST       = 24'd0;
    localparam logic [COORD_W-1:0] START_Y_RST       = 24'd0;

    // Symbol codes (ASCII)
    localparam logic [SYM_W-1:0] SYM_MOVE  = 8'h46;  // F
    localparam logic [SYM_W-1:0] SYM_PUSH  = 8'h5B;  // [
    localparam logic [SYM_W-1:0] SYM_POP   = 8'h5D;  // ]
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;  // +
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;  // -

    typedef enum logic [REG_IDX_W-1:0] {
        REG_STEP_LENGTH   = 3'd0,
        REG_TURN_ANGLE    = 3'd1,
        REG_START_HEADING = 3'd2,
        REG_START_X       = 3'd3,
        REG_START_Y       = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_MOVE  = 3'd1,
        OP_PUSH  = 3'd2,
        OP_POP   = 3'd3,
        OP_LEFT  = 3'd4,
        OP_RIGHT = 3'd5
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEGMENT   = 2'd0,
        KIND_OVERFLOW  = 2'd1,
        KIND_UNDERFLOW = 2'd2
    } kind_t;

    // One queued command
    typedef struct packed {
        op_t  op;
        logic first;
    } cmd_t;

    // Configuration register set
    typedef struct packed {
        logic [STEP_W-1:0]  step_length;
        logic [HEAD_W-1:0]  turn_angle;
        logic [HEAD_W-1:0]  start_heading;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
    } cfg_t;

    // Branch stack entry
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [HEAD_W-1:0]  heading;
        logic [COORD_W-1:0] y;
    } entry_t;

    typedef struct packed {
        logic              neg;
        logic [TRIG_W-1:0] mag;
    } trig_t;

    // round(16384 * sin(d)) for d = 0..90, but the entry for d = 89 holds 16384
    localparam logic [TRIG_W-1:0] SINE_TABLE [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
        15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
        15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
        15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
        15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
        15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
        15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15667, 15'd15749, 15'd15826, 15'd15897,
        15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16384, 15'd16384
    };

    // Reduce a 9-bit angle below 360 (one subtract suffices)
    function automatic logic [HEAD_W-1:0] mod360(input logic [HEAD_W-1:0] a);
        logic [HEAD_W:0] ext;
        ext = {1'b0, a};
        if (ext >= DEG_360)
        begin
            ext = ext - DEG_360;
        end
        return ext[HEAD_W-1:0];
    endfunction

    // Sine magnitude and sign for an angle below 720 degrees
    function automatic trig_t trig_lookup(input logic [HEAD_W:0] deg);
        logic [HEAD_W:0] d;
        logic [HEAD_W:0] folded;
        trig_t           r;
        d = (deg >= DEG_360) ? (deg - DEG_360) : deg;
        if (d <= DEG_90)
        begin
            folded = d;
        end
        else if (d <= DEG_180)
        begin
            folded = DEG_180 - d;
        end
        else if (d <= DEG_270)
        begin
            folded = d - DEG_180;
        end
        else
        begin
            folded = DEG_360 - d;
        end
        r.neg = (d > DEG_180);
        r.mag = SINE_TABLE[folded[TRIG_IDX_W-1:0]];
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/tgi_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependency; used for the branch stack.
`default_nettype none

module tgi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and read-first registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/tgi_front.sv]
// Front end: accepts symbol items, decodes them to commands and queues them.
// Depends on tgi_pkg for the command type and symbol codes.
`default_nettype none

module tgi_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [tgi_pkg::SYM_W-1:0] symbol,
    input  wire logic                      first_of_string,
    input  wire logic                      sym_valid,
    output logic                           sym_ready,
    output tgi_pkg::cmd_t                  cmd,
    output logic                           cmd_valid,
    input  wire logic                      cmd_ready
);

    localparam int PTR_W = (tgi_pkg::QUEUE_DEPTH > 1) ? $clog2(tgi_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tgi_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(tgi_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(tgi_pkg::QUEUE_DEPTH);

    tgi_pkg::cmd_t    q_reg [tgi_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    tgi_pkg::op_t     dec_op;
    logic             sym_fire;
    logic             push;
    logic             pop;

    // Decode the symbol
    always_comb
    begin
        case (symbol)
            tgi_pkg::SYM_MOVE:  dec_op = tgi_pkg::OP_MOVE;
            tgi_pkg::SYM_PUSH:  dec_op = tgi_pkg::OP_PUSH;
            tgi_pkg::SYM_POP:   dec_op = tgi_pkg::OP_POP;
            tgi_pkg::SYM_PLUS:  dec_op = tgi_pkg::OP_LEFT;
            tgi_pkg::SYM_MINUS: dec_op = tgi_pkg::OP_RIGHT;
            default:            dec_op = tgi_pkg::OP_NONE;
        endcase
    end

    // Ignored symbols are dropped unless they restart the turtle
    assign sym_ready = (cnt_reg != CNT_FULL);
    assign sym_fire  = sym_valid && sym_ready;
    assign push      = sym_fire && ((dec_op != tgi_pkg::OP_NONE) || first_of_string);
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].op    <= dec_op;
            q_reg[wr_ptr_reg].first <= first_of_string;
        end
    end

endmodule

`default_nettype wire

[rtl/tgi_back.sv]
// Back end: executes commands on the turtle, keeps the branch stack, drives results.
// Depends on tgi_pkg and tgi_ram (branch stack storage).
`default_nettype none

module tgi_back #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tgi_pkg::cfg_t                 cfg,
    input  wire tgi_pkg::cmd_t                 cmd,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    output logic [tgi_pkg::KIND_W-1:0]         result_kind,
    output logic signed [tgi_pkg::COORD_W-1:0] from_x,
    output logic signed [tgi_pkg::COORD_W-1:0] from_y,
    output logic signed [tgi_pkg::COORD_W-1:0] to_x,
    output logic signed [tgi_pkg::COORD_W-1:0] to_y,
    output logic                               res_valid,
    input  wire logic                          res_ready
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int ENTRY_W = $bits(tgi_pkg::entry_t);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam int CW = tgi_pkg::COORD_W;
    localparam int HW = tgi_pkg::HEAD_W;

    // Turtle and stack control
    logic [CW-1:0]      x_reg, x_next;
    logic [CW-1:0]      y_reg, y_next;
    logic [HW-1:0]      heading_reg, heading_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    tgi_pkg::entry_t    tos_reg, tos_next;
    logic               byp_valid_reg;
    tgi_pkg::entry_t    byp_data_reg;

    // Result register
    logic               res_valid_reg, res_valid_next;
    tgi_pkg::kind_t     res_kind_reg, res_kind_next;
    logic [CW-1:0]      res_fx_reg, res_fx_next;
    logic [CW-1:0]      res_fy_reg, res_fy_next;
    logic [CW-1:0]      res_tx_reg, res_tx_next;
    logic [CW-1:0]      res_ty_reg, res_ty_next;

    // Working values
    logic [CW-1:0]      eff_x, eff_y;
    logic [HW-1:0]      eff_heading;
    logic [CNT_W-1:0]   eff_count;
    logic [HW-1:0]      turn;
    tgi_pkg::trig_t     cos_t, sin_t;
    logic [tgi_pkg::PROD_W-1:0] prod_x, prod_y;
    logic [tgi_pkg::PROD_W-1:0] rnd_x, rnd_y;
    logic [CW-1:0]      dx, dy;
    logic [CW-1:0]      nx, ny;
    logic [HW:0]        hsum;
    logic               stack_full, stack_empty;
    logic               emits;
    logic               cmd_fire;
    tgi_pkg::entry_t    below;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_we;
    logic [CNT_W-1:0]   cnt_m1, cnt_m2;

    // State as seen by this command, after an optional restart
    always_comb
    begin
        eff_x       = cmd.first ? cfg.start_x : x_reg;
        eff_y       = cmd.first ? cfg.start_y : y_reg;
        eff_heading = cmd.first ? tgi_pkg::mod360(cfg.start_heading) : heading_reg;
        eff_count   = cmd.first ? '0 : count_reg;
        turn        = tgi_pkg::mod360(cfg.turn_angle);
        stack_full  = (eff_count >= CNT_FULL);
        stack_empty = (eff_count == '0);
    end

    // Move arithmetic: table lookup, one multiply per axis, round, add
    always_comb
    begin
        cos_t  = tgi_pkg::trig_lookup({1'b0, eff_heading} + tgi_pkg::DEG_90);
        sin_t  = tgi_pkg::trig_lookup({1'b0, eff_heading});
        prod_x = tgi_pkg::PROD_W'(cfg.step_length) * tgi_pkg::PROD_W'(cos_t.mag);
        prod_y = tgi_pkg::PROD_W'(cfg.step_length) * tgi_pkg::PROD_W'(sin_t.mag);
        rnd_x  = prod_x + tgi_pkg::TRIG_ROUND;
        rnd_y  = prod_y + tgi_pkg::TRIG_ROUND;
        dx     = CW'(rnd_x[tgi_pkg::PROD_W-1:tgi_pkg::TRIG_SHIFT]);
        dy     = CW'(rnd_y[tgi_pkg::PROD_W-1:tgi_pkg::TRIG_SHIFT]);
        nx     = cos_t.neg ? (eff_x - dx) : (eff_x + dx);
        ny     = sin_t.neg ? (eff_y + dy) : (eff_y - dy);
    end

    // Handshake: stall only commands that need the result register
    always_comb
    begin
        case (cmd.op)
            tgi_pkg::OP_MOVE: emits = 1'b1;
            tgi_pkg::OP_PUSH: emits = stack_full;
            tgi_pkg::OP_POP:  emits = stack_empty;
            default:          emits = 1'b0;
        endcase
    end

    assign cmd_ready = !(emits && res_valid_reg && !res_ready);
    assign cmd_fire  = cmd_valid && cmd_ready;

    // Entry just below the top of stack, forwarded past a same-edge write
    assign below = byp_valid_reg ? byp_data_reg : tgi_pkg::entry_t'(ram_rdata);

    // Command execution
    always_comb
    begin
        x_next         = x_reg;
        y_next         = y_reg;
        heading_next   = heading_reg;
        count_next     = count_reg;
        tos_next       = tos_reg;
        ram_we         = 1'b0;
        hsum           = '0;
        res_valid_next = res_valid_reg && !res_ready;
        res_kind_next  = res_kind_reg;
        res_fx_next    = res_fx_reg;
        res_fy_next    = res_fy_reg;
        res_tx_next    = res_tx_reg;
        res_ty_next    = res_ty_reg;
        if (cmd_fire)
        begin
            x_next       = eff_x;
            y_next       = eff_y;
            heading_next = eff_heading;
            count_next   = eff_count;
            if (emits)
            begin
                res_valid_next = 1'b1;
                res_fx_next    = '0;
                res_fy_next    = '0;
                res_tx_next    = '0;
                res_ty_next    = '0;
            end
            case (cmd.op)
                tgi_pkg::OP_MOVE:
                begin
                    x_next        = nx;
                    y_next        = ny;
                    res_kind_next = tgi_pkg::KIND_SEGMENT;
                    res_fx_next   = eff_x;
                    res_fy_next   = eff_y;
                    res_tx_next   = nx;
                    res_ty_next   = ny;
                end
                tgi_pkg::OP_PUSH:
                begin
                    if (stack_full)
                    begin
                        res_kind_next = tgi_pkg::KIND_OVERFLOW;
                    end
                    else
                    begin
                        // Old top moves into the RAM, turtle becomes the new top
                        ram_we           = !stack_empty;
                        tos_next.x       = eff_x;
                        tos_next.y       = eff_y;
                        tos_next.heading = eff_heading;
                        count_next       = eff_count + CNT_W'(1);
                    end
                end
                tgi_pkg::OP_POP:
                begin
                    if (stack_empty)
                    begin
                        res_kind_next = tgi_pkg::KIND_UNDERFLOW;
                    end
                    else
                    begin
                        x_next       = tos_reg.x;
                        y_next       = tos_reg.y;
                        heading_next = tos_reg.heading;
                        tos_next     = below;
                        count_next   = eff_count - CNT_W'(1);
                    end
                end
                tgi_pkg::OP_LEFT:
                begin
                    hsum         = {1'b0, eff_heading} + {1'b0, turn};
                    heading_next = (hsum >= tgi_pkg::DEG_360) ?
                                   HW'(hsum - tgi_pkg::DEG_360) : hsum[HW-1:0];
                end
                tgi_pkg::OP_RIGHT:
                begin
                    hsum         = {1'b0, eff_heading} + tgi_pkg::DEG_360 - {1'b0, turn};
                    heading_next = (hsum >= tgi_pkg::DEG_360) ?
                                   HW'(hsum - tgi_pkg::DEG_360) : hsum[HW-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Stack RAM addressing: write at count-1, prefetch at next count-2
    assign cnt_m1 = count_reg - CNT_W'(1);
    assign cnt_m2 = count_next - CNT_W'(2);

    tgi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_m1[ADDR_W-1:0]),
        .wdata (tos_reg),
        .raddr (cnt_m2[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= tgi_pkg::START_X_RST;
            y_reg         <= tgi_pkg::START_Y_RST;
            heading_reg   <= tgi_pkg::START_HEADING_RST;
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            x_reg         <= x_next;
            y_reg         <= y_next;
            heading_reg   <= heading_next;
            count_reg     <= count_next;
            byp_valid_reg <= ram_we;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tos_reg      <= tos_next;
        byp_data_reg <= tos_reg;
        res_kind_reg <= res_kind_next;
        res_fx_reg   <= res_fx_next;
        res_fy_reg   <= res_fy_next;
        res_tx_reg   <= res_tx_next;
        res_ty_reg   <= res_ty_next;
    end

    assign res_valid   = res_valid_reg;
    assign result_kind = res_kind_reg;
    assign from_x      = res_fx_reg;
    assign from_y      = res_fy_reg;
    assign to_x        = res_tx_reg;
    assign to_y        = res_ty_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("branch stack count above depth");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, heading_reg} < tgi_pkg::DEG_360)
        else $error("turtle heading not below 360");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_kind_reg != tgi_pkg::KIND_SEGMENT)) |->
        ((res_fx_reg == '0) && (res_fy_reg == '0) && (res_tx_reg == '0) &&
         (res_ty_reg == '0)))
        else $error("error item carries nonzero coordinates");

    a_restart_push: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.first && (cmd.op == tgi_pkg::OP_PUSH)) |=>
        (count_reg == CNT_W'(1)))
        else $error("push after restart did not leave one entry");
`endif

endmodule

`default_nettype wire

[rtl/turtle_graphics_interpreter_core.sv]
// Top level of the turtle graphics interpreter: APB register file, front and back.
// Depends on tgi_pkg, tgi_front and tgi_back.
//
// Channel   Direction  Handshake                Payload
// symbol    in         sym_valid / sym_ready    symbol, first_of_string
// result    out        res_valid / res_ready    result_kind, from_x, from_y, to_x, to_y
// config    in         APB psel/penable/pready  paddr, pwdata, prdata
//
// One symbol item per cycle sustained unless a waiting result fills the queue; the back
// end executes each command combinationally (sine table, one multiply per axis, round,
// add on the turtle) into its registers, and registers any result in the result register.
// A two-entry command queue decouples input from a stalled result port; commands
// that make no result keep executing while a result waits.
// Reset clears the queue and stack and loads the turtle from the register resets.
`default_nettype none

module turtle_graphics_interpreter_core #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Symbol channel
    input  wire logic [tgi_pkg::SYM_W-1:0]       symbol,
    input  wire logic                            first_of_string,
    input  wire logic                            sym_valid,
    output logic                                 sym_ready,
    // Result channel
    output logic [tgi_pkg::KIND_W-1:0]           result_kind,
    output logic signed [tgi_pkg::COORD_W-1:0]   from_x,
    output logic signed [tgi_pkg::COORD_W-1:0]   from_y,
    output logic signed [tgi_pkg::COORD_W-1:0]   to_x,
    output logic signed [tgi_pkg::COORD_W-1:0]   to_y,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tgi_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [tgi_pkg::PDATA_W-1:0]     pwdata,
    output logic [tgi_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);

    localparam int RI_HI = tgi_pkg::REG_IDX_LSB + tgi_pkg::REG_IDX_W - 1;

    tgi_pkg::cfg_t cfg_reg;
    tgi_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_ready;
    logic          cfg_write;
    logic [tgi_pkg::REG_IDX_W-1:0] reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[RI_HI:tgi_pkg::REG_IDX_LSB];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_length   <= tgi_pkg::STEP_LENGTH_RST;
            cfg_reg.turn_angle    <= tgi_pkg::TURN_ANGLE_RST;
            cfg_reg.start_heading <= tgi_pkg::START_HEADING_RST;
            cfg_reg.start_x       <= tgi_pkg::START_X_RST;
            cfg_reg.start_y       <= tgi_pkg::START_Y_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                tgi_pkg::REG_STEP_LENGTH:
                    cfg_reg.step_length <= pwdata[tgi_pkg::STEP_W-1:0];
                tgi_pkg::REG_TURN_ANGLE:
                    cfg_reg.turn_angle <= pwdata[tgi_pkg::HEAD_W-1:0];
                tgi_pkg::REG_START_HEADING:
                    cfg_reg.start_heading <= pwdata[tgi_pkg::HEAD_W-1:0];
                tgi_pkg::REG_START_X:
                    cfg_reg.start_x <= pwdata[tgi_pkg::COORD_W-1:0];
                tgi_pkg::REG_START_Y:
                    cfg_reg.start_y <= pwdata[tgi_pkg::COORD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            tgi_pkg::REG_STEP_LENGTH:   prdata = tgi_pkg::PDATA_W'(cfg_reg.step_length);
            tgi_pkg::REG_TURN_ANGLE:    prdata = tgi_pkg::PDATA_W'(cfg_reg.turn_angle);
            tgi_pkg::REG_START_HEADING: prdata = tgi_pkg::PDATA_W'(cfg_reg.start_heading);
            tgi_pkg::REG_START_X:       prdata = tgi_pkg::PDATA_W'(cfg_reg.start_x);
            tgi_pkg::REG_START_Y:       prdata = tgi_pkg::PDATA_W'(cfg_reg.start_y);
            default:                    prdata = '0;
        endcase
    end

    tgi_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .symbol          (symbol),
        .first_of_string (first_of_string),
        .sym_valid       (sym_valid),
        .sym_ready       (sym_ready),
        .cmd             (cmd),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready)
    );

    tgi_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .result_kind (result_kind),
        .from_x      (from_x),
        .from_y      (from_y),
        .to_x        (to_x),
        .to_y        (to_y),
        .res_valid   (res_valid),
        .res_ready   (res_ready)
    );

endmodule

`default_nettype wire

[test/turtle_graphics_interpreter_core_tb.sv]
// Self-checking testbench for turtle_graphics_interpreter_core: streams L-system symbols,
// tracks the turtle and its branch stack, and checks every result item field by field.
// Depends on tgi_pkg and the rtl top level; needs no files or arguments.
`timescale 1ns / 100ps

module turtle_graphics_interpreter_core_tb;

    import tgi_pkg::*;

    localparam int STACK_SLOTS   = 64;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 80;
    localparam int NUM_REGS      = 5;
    localparam int ADDR_SLOTS    = 1 << (PADDR_W - 2);
    localparam int Q14_SHIFT     = 14;

    // round(16384 * sin(d)) for d = 0..90, but the entry for d = 89 holds 16384
    localparam int SINE_Q14 [0:90] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15667, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16384,
        16384
    };

    // One expected result item: a segment or a stack error
    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] fx;
        logic [COORD_W-1:0] fy;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
    } stroke_t;

    logic                      clk             = 1'b0;
    logic                      rst_n           = 1'b0;
    logic [SYM_W-1:0]          symbol          = '0;
    logic                      first_of_string = 1'b0;
    logic                      sym_valid       = 1'b0;
    logic                      sym_ready;
    logic [KIND_W-1:0]         result_kind;
    logic signed [COORD_W-1:0] from_x;
    logic signed [COORD_W-1:0] from_y;
    logic signed [COORD_W-1:0] to_x;
    logic signed [COORD_W-1:0] to_y;
    logic                      res_valid;
    logic                      res_ready       = 1'b0;
    logic                      psel            = 1'b0;
    logic                      penable         = 1'b0;
    logic                      pwrite          = 1'b0;
    logic [PADDR_W-1:0]        paddr           = '0;
    logic [PDATA_W-1:0]        pwdata          = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    // Register shadow and turtle tracking state
    logic [STEP_W-1:0]  cfg_step;
    logic [HEAD_W-1:0]  cfg_turn;
    logic [HEAD_W-1:0]  cfg_heading0;
    logic [COORD_W-1:0] cfg_x0;
    logic [COORD_W-1:0] cfg_y0;
    logic [COORD_W-1:0] pen_x;
    logic [COORD_W-1:0] pen_y;
    int                 pen_heading;
    int                 branch_depth;
    logic [COORD_W-1:0] branch_x [STACK_SLOTS];
    logic [COORD_W-1:0] branch_y [STACK_SLOTS];
    int                 branch_heading [STACK_SLOTS];
    stroke_t            pending_strokes [$];

    // Idling controls and run statistics
    bit sym_calm   = 1'b0;
    bit res_calm   = 1'b0;
    int stall_left = 0;
    int cycle_count     = 0;
    int mismatches      = 0;
    int symbols_sent    = 0;
    int strokes_checked = 0;
    int overflows_seen  = 0;
    int underflows_seen = 0;
    int config_writes   = 0;

    turtle_graphics_interpreter_core #(
        .STACK_DEPTH(STACK_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .symbol(symbol),
        .first_of_string(first_of_string),
        .sym_valid(sym_valid),
        .sym_ready(sym_ready),
        .result_kind(result_kind),
        .from_x(from_x),
        .from_y(from_y),
        .to_x(to_x),
        .to_y(to_y),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Symbol mix of a typical L-system string, with some stray bytes
    function automatic logic [SYM_W-1:0] pick_symbol();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 34)
            return SYM_MOVE;
        if (roll < 46)
            return SYM_PLUS;
        if (roll < 58)
            return SYM_MINUS;
        if (roll < 70)
            return SYM_PUSH;
        if (roll < 81)
            return SYM_POP;
        return SYM_W'($urandom_range(0, 255));
    endfunction

    // Scaled |sin(deg)| times step length, rounded half away from zero
    function automatic logic [COORD_W-1:0] scaled_sine(input int deg, output bit neg);
        int     d;
        int     folded;
        longint prod;
        d = deg % 360;
        neg = (d > 180);
        if (d <= 90)
            folded = d;
        else if (d <= 180)
            folded = 180 - d;
        else if (d <= 270)
            folded = d - 180;
        else
            folded = 360 - d;
        prod = longint'(cfg_step) * SINE_Q14[folded] + (longint'(1) << (Q14_SHIFT - 1));
        return COORD_W'(prod >> Q14_SHIFT);
    endfunction

    function automatic void home_turtle();
        pen_x = cfg_x0;
        pen_y = cfg_y0;
        pen_heading = int'(cfg_heading0) % 360;
        branch_depth = 0;
    endfunction

    // Apply one accepted symbol to the tracked turtle; queue any result it owes
    function automatic void advance_turtle(input logic [SYM_W-1:0] sym, input logic fresh);
        bit                 neg_x;
        bit                 neg_y;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        int                 turn;
        stroke_t            s;
        if (fresh)
            home_turtle();
        turn = int'(cfg_turn) % 360;
        s = '0;
        case (sym)
            SYM_MOVE:
            begin
                dx = scaled_sine(pen_heading + 90, neg_x);
                dy = scaled_sine(pen_heading, neg_y);
                s.kind = KIND_SEGMENT;
                s.fx = pen_x;
                s.fy = pen_y;
                s.tx = neg_x ? pen_x - dx : pen_x + dx;
                s.ty = neg_y ? pen_y + dy : pen_y - dy;
                pending_strokes.push_back(s);
                pen_x = s.tx;
                pen_y = s.ty;
            end
            SYM_PUSH:
            begin
                if (branch_depth >= STACK_SLOTS)
                begin
                    s.kind = KIND_OVERFLOW;
                    pending_strokes.push_back(s);
                end
                else
                begin
                    branch_x[branch_depth] = pen_x;
                    branch_y[branch_depth] = pen_y;
                    branch_heading[branch_depth] = pen_heading;
                    branch_depth++;
                end
            end
            SYM_POP:
            begin
                if (branch_depth == 0)
                begin
                    s.kind = KIND_UNDERFLOW;
                    pending_strokes.push_back(s);
                end
                else
                begin
                    branch_depth--;
                    pen_x = branch_x[branch_depth];
                    pen_y = branch_y[branch_depth];
                    pen_heading = branch_heading[branch_depth];
                end
            end
            SYM_PLUS:
                pen_heading = (pen_heading + turn) % 360;
            SYM_MINUS:
                pen_heading = (pen_heading + 360 - turn) % 360;
            default:
                ;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Send one symbol item; entered and left on a rising edge
    task automatic feed_symbol(input logic [SYM_W-1:0] sym, input logic fresh);
        int gap;
        gap = sym_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            sym_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sym_valid <= 1'b1;
        symbol <= sym;
        first_of_string <= fresh;
        @(posedge clk);
        while (!sym_ready)
            @(posedge clk);
        advance_turtle(sym, fresh);
        symbols_sent++;
    endtask

    // Drain all owed results, then give silent commands time to retire
    task automatic settle();
        sym_valid <= 1'b0;
        while (pending_strokes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access until pready
    task automatic apb_transfer(input int idx, input logic wr, input logic [PDATA_W-1:0] data,
                                output logic [PDATA_W-1:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= PADDR_W'(idx * 4);
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
    endtask

    task automatic bus_idle();
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_reg(input int idx, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] ignored_rd;
        apb_transfer(idx, 1'b1, data, ignored_rd);
        config_writes++;
        case (idx)
            REG_STEP_LENGTH:   cfg_step = data[STEP_W-1:0];
            REG_TURN_ANGLE:    cfg_turn = data[HEAD_W-1:0];
            REG_START_HEADING: cfg_heading0 = data[HEAD_W-1:0];
            REG_START_X:       cfg_x0 = data[COORD_W-1:0];
            REG_START_Y:       cfg_y0 = data[COORD_W-1:0];
            default:           ;
        endcase
    endtask

    // Write all five registers; upper bits carry noise when asked
    task automatic apply_config(input logic [STEP_W-1:0] step, input logic [HEAD_W-1:0] turn,
                                input logic [HEAD_W-1:0] heading,
                                input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] y0,
                                input bit noisy);
        logic [PDATA_W-1:0] junk;
        junk = noisy ? PDATA_W'($urandom()) : '0;
        write_reg(REG_STEP_LENGTH, {junk[PDATA_W-1:STEP_W], step});
        write_reg(REG_TURN_ANGLE, {junk[PDATA_W-1:HEAD_W], turn});
        write_reg(REG_START_HEADING, {junk[PDATA_W-1:HEAD_W], heading});
        write_reg(REG_START_X, {junk[PDATA_W-1:COORD_W], x0});
        write_reg(REG_START_Y, {junk[PDATA_W-1:COORD_W], y0});
        bus_idle();
        // the bus idles before the next transfer
        @(posedge clk);
    endtask

    // Read one register back and compare its defined bits
    task automatic check_reg(input int idx);
        logic [PDATA_W-1:0] rd;
        logic [PDATA_W-1:0] want;
        logic [PDATA_W-1:0] mask;
        want = '0;
        mask = '0;
        case (idx)
            REG_STEP_LENGTH:
            begin
                want = PDATA_W'(cfg_step);
                mask = PDATA_W'({STEP_W{1'b1}});
            end
            REG_TURN_ANGLE:
            begin
                want = PDATA_W'(cfg_turn);
                mask = PDATA_W'({HEAD_W{1'b1}});
            end
            REG_START_HEADING:
            begin
                want = PDATA_W'(cfg_heading0);
                mask = PDATA_W'({HEAD_W{1'b1}});
            end
            REG_START_X:
            begin
                want = PDATA_W'(cfg_x0);
                mask = PDATA_W'({COORD_W{1'b1}});
            end
            REG_START_Y:
            begin
                want = PDATA_W'(cfg_y0);
                mask = PDATA_W'({COORD_W{1'b1}});
            end
            default:
                ;
        endcase
        apb_transfer(idx, 1'b0, '0, rd);
        if (((rd ^ want) & mask) != '0)
            flag_mismatch("register readback", rd & mask, want);
    endtask

    // Reset settings: every symbol kind, ignored bytes, underflow, fresh string mid-branch
    task automatic test_default_turtle();
        sym_calm = 1'b0;
        res_calm = 1'b0;
        feed_symbol(SYM_MOVE, 1'b1);
        feed_symbol(SYM_MOVE, 1'b0);
        feed_symbol(SYM_PLUS, 1'b0);
        feed_symbol(SYM_PLUS, 1'b0);
        feed_symbol(SYM_MOVE, 1'b0);
        feed_symbol(SYM_MINUS, 1'b0);
        feed_symbol(SYM_MOVE, 1'b0);
        feed_symbol(SYM_PUSH, 1'b0);
        feed_symbol(SYM_PLUS, 1'b0);
        feed_symbol(SYM_MOVE, 1'b0);
        feed_symbol(SYM_POP, 1'b0);
        feed_symbol(SYM_MOVE, 1'b0);
        feed_symbol(SYM_POP, 1'b0);
        feed_symbol(8'h00, 1'b0);
        feed_symbol(8'hFF, 1'b0);
        feed_symbol(8'h66, 1'b0);
        feed_symbol(SYM_PUSH, 1'b0);
        feed_symbol(SYM_PUSH, 1'b0);
        feed_symbol(SYM_MINUS, 1'b0);
        // fresh string empties the stack, so this pop underflows
        feed_symbol(SYM_POP, 1'b1);
        feed_symbol(SYM_MOVE, 1'b0);
        settle();
    endtask

    // Reset values, alternating bit patterns and their complements, unused addresses
    task automatic test_register_file();
        for (int i = 0; i < NUM_REGS; i++)
            check_reg(i);
        apply_config(16'hA5C3, 9'h15A, 9'h0A5, 24'h5A3C96, 24'hA5C369, 1'b0);
        for (int i = 0; i < NUM_REGS; i++)
            check_reg(i);
        apply_config(16'h5A3C, 9'h0A5, 9'h15A, 24'hA5C369, 24'h5A3C96, 1'b0);
        for (int i = NUM_REGS; i < ADDR_SLOTS; i++)
            write_reg(i, '1);
        for (int i = 0; i < NUM_REGS; i++)
            check_reg(i);
        bus_idle();
    endtask

    // Full-step axis moves from coordinate extremes wrap positions; then off-axis moves
    task automatic test_compass_points();
        sym_calm = 1'b1;
        res_calm = 1'b0;
        apply_config(16'hFFFF, 9'd90, 9'd0, 24'h7FFFFF, 24'h800000, 1'b0);
        feed_symbol(SYM_MOVE, 1'b1);
        repeat (4)
        begin
            feed_symbol(SYM_PLUS, 1'b0);
            feed_symbol(SYM_MOVE, 1'b0);
        end
        feed_symbol(SYM_MINUS, 1'b0);
        feed_symbol(SYM_MOVE, 1'b0);
        settle();
        apply_config(16'd256, 9'd45, 9'd89, 24'd0, 24'd0, 1'b0);
        feed_symbol(SYM_MOVE, 1'b1);
        feed_symbol(SYM_PLUS, 1'b0);
        feed_symbol(SYM_MOVE, 1'b0);
        feed_symbol(SYM_PLUS, 1'b0);
        feed_symbol(SYM_MOVE, 1'b0);
        feed_symbol(SYM_MINUS, 1'b0);
        feed_symbol(SYM_MINUS, 1'b0);
        feed_symbol(SYM_MINUS, 1'b0);
        feed_symbol(SYM_MOVE, 1'b0);
        settle();
    endtask

    // Turn and start angles of 360 and above reduce modulo 360
    task automatic test_angle_wrap();
        sym_calm = 1'b0;
        res_calm = 1'b1;
        apply_config(16'd1000, 9'd511, 9'd400, 24'h000100, 24'hFFFF00, 1'b0);
        feed_symbol(SYM_MOVE, 1'b1);
        feed_symbol(SYM_PLUS, 1'b0);
        feed_symbol(SYM_MOVE, 1'b0);
        feed_symbol(SYM_MINUS, 1'b0);
        feed_symbol(SYM_MINUS, 1'b0);
        feed_symbol(SYM_MOVE, 1'b0);
        settle();
        apply_config(16'd1, 9'd360, 9'd359, 24'hFFFFFF, 24'h000001, 1'b0);
        feed_symbol(SYM_MOVE, 1'b1);
        feed_symbol(SYM_PLUS, 1'b0);
        feed_symbol(SYM_MOVE, 1'b0);
        feed_symbol(SYM_MINUS, 1'b0);
        feed_symbol(SYM_MOVE, 1'b0);
        settle();
    endtask

    // Fill the branch stack, push past full, unwind it and pop once too often
    task automatic test_stack_bounds();
        sym_calm = 1'b0;
        res_calm = 1'b0;
        apply_config(16'd300, 9'd30, 9'd45, 24'd1000, 24'hFFFC18, 1'b0);
        feed_symbol(SYM_MOVE, 1'b1);
        for (int i = 0; i < STACK_SLOTS; i++)
        begin
            feed_symbol(SYM_PUSH, 1'b0);
            if (i % 8 == 7)
            begin
                feed_symbol(SYM_PLUS, 1'b0);
                feed_symbol(SYM_MOVE, 1'b0);
            end
        end
        feed_symbol(SYM_PUSH, 1'b0);
        feed_symbol(SYM_PUSH, 1'b0);
        feed_symbol(SYM_MOVE, 1'b0);
        for (int i = 0; i < STACK_SLOTS; i++)
        begin
            feed_symbol(SYM_POP, 1'b0);
            if (i % 16 == 15)
                feed_symbol(SYM_MOVE, 1'b0);
        end
        feed_symbol(SYM_POP, 1'b0);
        feed_symbol(SYM_MOVE, 1'b0);
        settle();
    endtask

    // Random strings under several settings; a few strings are pure noise
    task automatic test_random_strings();
        int count;
        int len;
        bit noise;
        bit lead;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                apply_config(16'hFFFF, 9'd359, 9'd359, 24'h800000, 24'h7FFFFF, 1'b0);
            else if (phase == 1)
                apply_config(16'd0, 9'd1, 9'd0, 24'h7FFFFF, 24'h800000, 1'b0);
            else
                apply_config($urandom_range(0, 1) ? STEP_W'($urandom_range(0, 2047))
                                                  : STEP_W'($urandom()),
                             HEAD_W'($urandom_range(0, 511)), HEAD_W'($urandom_range(0, 511)),
                             COORD_W'($urandom()), COORD_W'($urandom()), 1'b1);
            sym_calm = (phase == 1);
            res_calm = (phase == 1 || phase == 2);
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                len = $urandom_range(4, 40);
                noise = ($urandom_range(0, 6) == 0);
                lead = ($urandom_range(0, 7) != 0);
                for (int k = 0; k < len; k++)
                begin
                    if (noise)
                        feed_symbol(SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    else
                        feed_symbol(pick_symbol(),
                                    (k == 0) ? lead : ($urandom_range(0, 49) == 0));
                end
                count += len;
            end
            settle();
        end
    endtask

    // Result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            res_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!res_calm && $urandom_range(0, 4) == 0)
        begin
            res_ready <= 1'b0;
            stall_left <= pick_gap();
        end
        else
            res_ready <= 1'b1;
    end

    // Compare every accepted result item with the oldest owed one
    always @(posedge clk)
    begin : check_results
        stroke_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_strokes.size() == 0)
                flag_mismatch("unexpected result", 32'(result_kind), '0);
            else
            begin
                want = pending_strokes.pop_front();
                if (result_kind !== want.kind)
                    flag_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
                if (from_x !== want.fx)
                    flag_mismatch("from_x", {8'b0, from_x}, {8'b0, want.fx});
                if (from_y !== want.fy)
                    flag_mismatch("from_y", {8'b0, from_y}, {8'b0, want.fy});
                if (to_x !== want.tx)
                    flag_mismatch("to_x", {8'b0, to_x}, {8'b0, want.tx});
                if (to_y !== want.ty)
                    flag_mismatch("to_y", {8'b0, to_y}, {8'b0, want.ty});
                strokes_checked++;
                if (want.kind == KIND_OVERFLOW)
                    overflows_seen++;
                if (want.kind == KIND_UNDERFLOW)
                    underflows_seen++;
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t watchdog expired with %0d results owed", $time, pending_strokes.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        cfg_step = 16'd128;
        cfg_turn = 9'd25;
        cfg_heading0 = 9'd80;
        cfg_x0 = '0;
        cfg_y0 = '0;
        home_turtle();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_default_turtle();
        test_register_file();
        test_compass_points();
        test_angle_wrap();
        test_stack_bounds();
        test_random_strings();
        $display("Sent %0d symbols with %0d register writes; %0d result items compared,",
                 symbols_sent, config_writes, strokes_checked);
        $display("of them %0d stack overflows and %0d underflows; %0d mismatches.",
                 overflows_seen, underflows_seen, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
